// ===== rtl/cbus_pkg.sv =====
// ----------------------------------------------------------------------------
// cbus_pkg
// Shared constants, codes, word types and address decode for the console
// cpu bus with sprite dma.
// ----------------------------------------------------------------------------
`default_nettype none

package cbus_pkg;

    // sizing (ram size must be a power of two)
    localparam int RAM_BYTES  = 2048;
    localparam int CPU_DIVIDE = 3;
    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int TICK_W     = (CPU_DIVIDE > 1) ? $clog2(CPU_DIVIDE) : 1;

    // request modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // access targets
    localparam logic [2:0] TGT_RAM  = 3'd0;
    localparam logic [2:0] TGT_PAD  = 3'd1;
    localparam logic [2:0] TGT_PPU  = 3'd2;
    localparam logic [2:0] TGT_CART = 3'd3;
    localparam logic [2:0] TGT_DMA  = 3'd4;
    localparam logic [2:0] TGT_NONE = 3'd5;

    // address map
    localparam logic [15:0] RAM_TOP  = 16'h1FFF;
    localparam logic [15:0] PPU_LO   = 16'h2000;
    localparam logic [15:0] PPU_HI   = 16'h3FFF;
    localparam logic [15:0] DMA_TRIG = 16'h4014;
    localparam logic [15:0] PAD0     = 16'h4016;
    localparam logic [15:0] PAD1     = 16'h4017;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] addr;
        logic [7:0]  write_data;
        logic [7:0]  ext_read_data;
        logic        ext_read_ok;
        logic [7:0]  pad_buttons_0;
        logic [7:0]  pad_buttons_1;
        logic        nmi_request;
    } req_word_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        accepted;
        logic [2:0]  target;
        logic [15:0] dma_source_addr;
        logic        cpu_step;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        nmi_to_cpu;
        logic        dma_busy;
    } rsp_word_t;

    // read-side decode, shared by cpu reads and dma source reads
    function automatic logic [2:0] read_target(input logic [15:0] a);
        logic [2:0] t;
        if (a <= RAM_TOP)
            t = TGT_RAM;
        else if (a == PAD0 || a == PAD1)
            t = TGT_PAD;
        else if (a >= PPU_LO && a <= PPU_HI)
            t = TGT_PPU;
        else
            t = TGT_CART;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cbus_ram.sv =====
// ----------------------------------------------------------------------------
// cbus_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/console_cpu_bus_with_sprite_dma_core.sv =====
// ----------------------------------------------------------------------------
// console_cpu_bus_with_sprite_dma_core
// CPU bus decode with mirrored work ram, controller ports and sprite dma.
// ----------------------------------------------------------------------------
// throughput: one request word per cycle, sustained, with rsp_stall low and the ram clear done
// the single ram read port sets the pipeline: read data lands in the cycle after the read
// reset: rst_n is asynchronous; after release the work ram is cleared one byte
// a cycle, all RAM_BYTES (2048) bytes, with req_stall held high
`default_nettype none

module console_cpu_bus_with_sprite_dma_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire cbus_pkg::req_word_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output cbus_pkg::rsp_word_t      rsp
);

    import cbus_pkg::*;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    // ram clearing pass
    logic              clear_reg,  clear_next;
    logic [RAM_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // bus state
    logic [7:0]        pad_reg [2];
    logic [7:0]        pad_next [2];
    logic [7:0]        page_reg,   page_next;
    logic [7:0]        index_reg,  index_next;
    logic [7:0]        latch_reg,  latch_next;
    logic              active_reg, active_next;
    logic              phase_reg,  phase_next;
    logic [TICK_W-1:0] tick_reg,   tick_next;

    // a dma source read from ram is in flight; latch picks it up next edge
    logic              pend_reg,   pend_next;

    // stage 1: ram read in flight
    logic              s1_valid_reg, s1_valid_next;
    rsp_word_t         s1_word_reg,  s1_word_next;
    logic              s1_ram_reg,   s1_ram_next;

    // output register
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_word_reg,  rsp_word_next;

    // ------------------------------------------------------------------
    // ram port
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // request side control
    logic              out_free;
    logic              req_fire;
    logic              cpu_we;
    logic [2:0]        rd_tgt;
    logic [2:0]        src_tgt;
    logic [15:0]       src_addr;
    logic              pad_sel;
    logic              src_pad_sel;
    rsp_word_t         res;
    logic              res_ram;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = clear_reg || (s1_valid_reg && !out_free);
    assign req_fire  = req_valid && !req_stall;

    assign pad_sel     = req.addr[0];
    assign rd_tgt      = read_target(req.addr);
    assign src_addr    = {page_reg, index_reg};
    assign src_tgt     = read_target(src_addr);
    assign src_pad_sel = src_addr[0];

    // ------------------------------------------------------------------
    // single-pass item logic: state update and partial response
    // ------------------------------------------------------------------
    always_comb
    begin
        res          = '0;
        res.target   = TGT_NONE;
        res_ram      = 1'b0;
        cpu_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = req.addr[RAM_AW-1:0];

        pad_next[0]  = pad_reg[0];
        pad_next[1]  = pad_reg[1];
        page_next    = page_reg;
        index_next   = index_reg;
        active_next  = active_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        pend_next    = 1'b0;
        // ram source data from the previous edge lands in the latch now
        latch_next   = pend_reg ? ram_rdata : latch_reg;

        if (req_fire)
        begin
            case (req.mode)
                MODE_WRITE:
                begin
                    if (req.addr <= RAM_TOP)
                    begin
                        cpu_we       = 1'b1;
                        res.target   = TGT_RAM;
                        res.accepted = 1'b1;
                    end
                    else if (req.addr == PAD0 || req.addr == PAD1)
                    begin
                        pad_next[pad_sel] = pad_sel ? req.pad_buttons_1
                                                    : req.pad_buttons_0;
                        res.target   = TGT_PAD;
                        res.accepted = 1'b1;
                    end
                    else if (req.addr <= PPU_HI)
                    begin
                        res.target   = TGT_PPU;
                        res.accepted = 1'b1;
                    end
                    else if (req.addr == DMA_TRIG)
                    begin
                        // also restarts a running transfer
                        page_next    = req.write_data;
                        index_next   = 8'd0;
                        phase_next   = 1'b0;
                        active_next  = 1'b1;
                        res.target   = TGT_DMA;
                        res.accepted = 1'b1;
                    end
                end

                MODE_READ:
                begin
                    res.target = rd_tgt;
                    case (rd_tgt)
                        TGT_RAM:
                        begin
                            ram_re       = 1'b1;
                            res_ram      = 1'b1;
                            res.accepted = 1'b1;
                        end
                        TGT_PAD:
                        begin
                            res.read_data     = {7'd0, pad_reg[pad_sel][7]};
                            pad_next[pad_sel] = {pad_reg[pad_sel][6:0], 1'b0};
                            res.accepted      = 1'b1;
                        end
                        default:
                        begin
                            if (req.ext_read_ok)
                            begin
                                res.read_data = req.ext_read_data;
                                res.accepted  = 1'b1;
                            end
                        end
                    endcase
                end

                MODE_TICK:
                begin
                    if (tick_reg == '0)
                    begin
                        if (active_reg)
                        begin
                            if (!phase_reg)
                            begin
                                // source read step
                                res.dma_source_addr = src_addr;
                                phase_next          = 1'b1;
                                case (src_tgt)
                                    TGT_RAM:
                                    begin
                                        ram_re    = 1'b1;
                                        ram_raddr = src_addr[RAM_AW-1:0];
                                        pend_next = 1'b1;
                                    end
                                    TGT_PAD:
                                    begin
                                        latch_next = {7'd0, pad_reg[src_pad_sel][7]};
                                        pad_next[src_pad_sel] =
                                            {pad_reg[src_pad_sel][6:0], 1'b0};
                                    end
                                    default:
                                    begin
                                        if (req.ext_read_ok)
                                        begin
                                            latch_next = req.ext_read_data;
                                        end
                                    end
                                endcase
                            end
                            else
                            begin
                                // sprite memory write step; forward a ram
                                // source byte that has not reached the latch
                                res.oam_write = 1'b1;
                                res.oam_index = index_reg;
                                res.oam_data  = pend_reg ? ram_rdata : latch_reg;
                                index_next    = 8'(index_reg + 8'd1);
                                phase_next    = 1'b0;
                                if (index_reg == 8'hFF)
                                begin
                                    active_next = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            res.cpu_step = 1'b1;
                        end
                    end
                    res.nmi_to_cpu = req.nmi_request;
                    if (tick_reg == TICK_W'(CPU_DIVIDE - 1))
                        tick_next = '0;
                    else
                        tick_next = TICK_W'(tick_reg + 1'b1);
                end

                default:
                begin
                end
            endcase
        end

        res.dma_busy = active_next;
    end

    // ------------------------------------------------------------------
    // ram write port: clearing pass or cpu write
    // ------------------------------------------------------------------
    assign ram_we    = clear_reg || cpu_we;
    assign ram_waddr = clear_reg ? clr_cnt_reg : req.addr[RAM_AW-1:0];
    assign ram_wdata = clear_reg ? 8'd0 : req.write_data;

    assign clr_cnt_next = clear_reg ? RAM_AW'(clr_cnt_reg + 1'b1) : clr_cnt_reg;
    assign clear_next   = clear_reg && (clr_cnt_reg != '1);

    cbus_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_work_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // pipeline: stage 1 waits for ram data, then the output register
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_word_next   = s1_word_reg;
        s1_ram_next    = s1_ram_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;

        if (out_free)
        begin
            rsp_valid_next = s1_valid_reg;
            rsp_word_next  = s1_word_reg;
            if (s1_ram_reg)
            begin
                rsp_word_next.read_data = ram_rdata;
            end
            s1_valid_next = 1'b0;
        end

        if (req_fire)
        begin
            s1_valid_next = 1'b1;
            s1_word_next  = res;
            s1_ram_next   = res_ram;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_word_reg;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            pad_reg[0]    <= 8'd0;
            pad_reg[1]    <= 8'd0;
            page_reg      <= 8'd0;
            index_reg     <= 8'd0;
            latch_reg     <= 8'd0;
            active_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            tick_reg      <= '0;
            pend_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clr_cnt_reg   <= clr_cnt_next;
            pad_reg[0]    <= pad_next[0];
            pad_reg[1]    <= pad_next[1];
            page_reg      <= page_next;
            index_reg     <= index_next;
            latch_reg     <= latch_next;
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            pend_reg      <= pend_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_word_reg  <= s1_word_next;
        s1_ram_reg   <= s1_ram_next;
        rsp_word_reg <= rsp_word_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // no request taken while the ram is being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> req_stall)
        else $error("request accepted during ram clearing");

    // pending is cleared by default after a dma ram read, so pending lasts one cycle
    a_pend_one: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> !pend_reg)
        else $error("dma latch pending for more than one cycle");

    // a tick never both runs the cpu and writes sprite memory
    a_tick_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_word_reg.cpu_step && rsp_word_reg.oam_write))
        else $error("cpu step and sprite write on the same tick");

    // a stalled stage 1 word is not dropped
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("stage 1 word lost under stall");

    // dma is busy after every sprite write except the last byte
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_word_reg.oam_write && rsp_word_reg.oam_index != 8'hFF)
        |-> rsp_word_reg.dma_busy)
        else $error("dma ended before the last byte");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the console cpu bus with sprite dma. A short table of
// directed words comes first. Two random parts follow: a long stretch of one
// sprite transfer with cpu traffic mixed in, then mixed traffic with restarts.
// Each response word is checked field by field against its table row if typed,
// else against an in-bench model of the bus, controller ports and dma engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import cbus_pkg::*;

    // the mode field is two bits wide; the fourth code does nothing
    localparam logic [1:0] MODE_NONE = 2'd3;

    // cycles with no movement on either side before the run is called hung
    // (covers the ram clearing pass after reset many times over)
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int XFER_WORDS     = 330;
    localparam int MIX_WORDS      = 750;
    localparam int CALM_WORDS     = 150;
    localparam int N_DIR          = 25;

    // one row of the directed table: request fields, then a flag saying
    // whether the expected response is given here, then that response
    // (fields not listed are zero in every typed row)
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] addr;
        logic [7:0]  wd;
        logic [7:0]  ext;
        logic        ok;
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic        nmi;
        logic        chk;
        logic [7:0]  rd;
        logic        acc;
        logic [2:0]  tgt;
        logic        cpu;
        logic        nmo;
        logic        busy;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [N_DIR] = '{
        // ram right after reset reads zero
        '{MODE_READ,  16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b1, 8'h00, 1'b1, TGT_RAM,  1'b0, 1'b0, 1'b0},
        '{MODE_WRITE, 16'h0000, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b1, 8'h00, 1'b1, TGT_RAM,  1'b0, 1'b0, 1'b0},
        // top mirror of byte zero
        '{MODE_READ,  16'h1800, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b1, 8'hFF, 1'b1, TGT_RAM,  1'b0, 1'b0, 1'b0},
        '{MODE_WRITE, 16'h07FF, 8'hA5, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        '{MODE_READ,  16'h1FFF, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        // controller load, then shift out msb first
        '{MODE_WRITE, 16'h4016, 8'h00, 8'h00, 1'b0, 8'h80, 8'h00, 1'b0,
          1'b1, 8'h00, 1'b1, TGT_PAD,  1'b0, 1'b0, 1'b0},
        '{MODE_READ,  16'h4016, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b1, 8'h01, 1'b1, TGT_PAD,  1'b0, 1'b0, 1'b0},
        '{MODE_READ,  16'h4016, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b1, 8'h00, 1'b1, TGT_PAD,  1'b0, 1'b0, 1'b0},
        '{MODE_WRITE, 16'h4017, 8'h00, 8'h00, 1'b0, 8'h00, 8'hFF, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        '{MODE_READ,  16'h4017, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        // ppu writes are forwarded and always taken
        '{MODE_WRITE, 16'h2000, 8'h12, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b1, 8'h00, 1'b1, TGT_PPU,  1'b0, 1'b0, 1'b0},
        '{MODE_WRITE, 16'h3FFF, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        // external reads: answered, then refused
        '{MODE_READ,  16'h2002, 8'h00, 8'h5A, 1'b1, 8'h00, 8'h00, 1'b0,
          1'b1, 8'h5A, 1'b1, TGT_PPU,  1'b0, 1'b0, 1'b0},
        '{MODE_READ,  16'h8000, 8'h00, 8'h33, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b1, 8'h00, 1'b0, TGT_CART, 1'b0, 1'b0, 1'b0},
        '{MODE_READ,  16'hFFFF, 8'h00, 8'hFF, 1'b1, 8'h00, 8'h00, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        // writes to holes in the io page are dropped
        '{MODE_WRITE, 16'h4000, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b1, 8'h00, 1'b0, TGT_NONE, 1'b0, 1'b0, 1'b0},
        '{MODE_WRITE, 16'h4015, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        '{MODE_WRITE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        // a read of the dma trigger address goes to the cartridge
        '{MODE_READ,  16'h4014, 8'h00, 8'h77, 1'b1, 8'h00, 8'h00, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        // unused mode code with every field high
        '{MODE_NONE,  16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1,
          1'b1, 8'h00, 1'b0, TGT_NONE, 1'b0, 1'b0, 1'b0},
        // first tick after reset is an active one, nmi passes through
        '{MODE_TICK,  16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1,
          1'b1, 8'h00, 1'b0, TGT_NONE, 1'b1, 1'b1, 1'b0},
        // start a transfer from page zero and step into its first read
        '{MODE_WRITE, 16'h4014, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b1, 8'h00, 1'b1, TGT_DMA,  1'b0, 1'b0, 1'b1},
        '{MODE_TICK,  16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        '{MODE_TICK,  16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0},
        '{MODE_TICK,  16'h0000, 8'h00, 8'hC3, 1'b1, 8'h00, 8'h00, 1'b0,
          1'b0, 8'h00, 1'b0, TGT_RAM,  1'b0, 1'b0, 1'b0}
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;

    console_cpu_bus_with_sprite_dma_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // bench copy of the bus state
    logic [7:0] ram_img [RAM_BYTES];
    logic [7:0] pad_sr [2];
    logic [7:0] dma_pg;
    logic [7:0] dma_idx;
    logic [7:0] dma_buf;
    logic       dma_on;
    logic       dma_wr_phase;
    int         tick_cnt;

    rsp_word_t  rsp_q [$];     // response words still owed by the block
    bit         drv_typed;     // word on the bus carries a typed expectation
    rsp_word_t  drv_typed_rsp;
    int         err_cnt = 0;
    int         idle_cycles = 0;
    int         sent_cnt = 0;
    int         rsp_cnt = 0;
    bit         calm = 1'b0;   // no gaps and no stalls in the closing stretch

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shared bus read, used by cpu reads and by the dma source read;
    // returns whether the access was answered
    function automatic bit bus_fetch(input logic [15:0] a, input logic [7:0] ext,
                                     input logic ok, output logic [7:0] d,
                                     output logic [2:0] t);
        bit hit;
        hit = 1'b1;
        d = 8'h00;
        if (a <= RAM_TOP)
        begin
            d = ram_img[a[RAM_AW-1:0]];
            t = TGT_RAM;
        end
        else if (a == PAD0 || a == PAD1)
        begin
            // serial port: msb comes out, register shifts up with zero fill
            d = {7'd0, pad_sr[a[0]][7]};
            pad_sr[a[0]] = {pad_sr[a[0]][6:0], 1'b0};
            t = TGT_PAD;
        end
        else
        begin
            t = (a >= PPU_LO && a <= PPU_HI) ? TGT_PPU : TGT_CART;
            hit = ok;
            d = ext;
        end
        return hit;
    endfunction

    // response word for one request word, advancing the bench state
    function automatic rsp_word_t bus_predict(input req_word_t w);
        rsp_word_t   r;
        logic [7:0]  d;
        logic [2:0]  t;
        logic [15:0] s;
        r = '0;
        r.target = TGT_NONE;
        case (w.mode)
            MODE_WRITE:
            begin
                if (w.addr <= RAM_TOP)
                begin
                    ram_img[w.addr[RAM_AW-1:0]] = w.write_data;
                    r.target = TGT_RAM;
                    r.accepted = 1'b1;
                end
                else if (w.addr == PAD0 || w.addr == PAD1)
                begin
                    pad_sr[w.addr[0]] = w.addr[0] ? w.pad_buttons_1 : w.pad_buttons_0;
                    r.target = TGT_PAD;
                    r.accepted = 1'b1;
                end
                else if (w.addr <= PPU_HI)
                begin
                    r.target = TGT_PPU;
                    r.accepted = 1'b1;
                end
                else if (w.addr == DMA_TRIG)
                begin
                    // also restarts a transfer already under way
                    dma_pg = w.write_data;
                    dma_idx = 8'h00;
                    dma_wr_phase = 1'b0;
                    dma_on = 1'b1;
                    r.target = TGT_DMA;
                    r.accepted = 1'b1;
                end
            end
            MODE_READ:
            begin
                if (bus_fetch(w.addr, w.ext_read_data, w.ext_read_ok, d, t))
                begin
                    r.accepted = 1'b1;
                    r.read_data = d;
                end
                r.target = t;
            end
            MODE_TICK:
            begin
                if (tick_cnt == 0)
                begin
                    if (dma_on && !dma_wr_phase)
                    begin
                        // source read; a refused external read keeps the latch
                        s = {dma_pg, dma_idx};
                        if (bus_fetch(s, w.ext_read_data, w.ext_read_ok, d, t))
                            dma_buf = d;
                        r.dma_source_addr = s;
                        dma_wr_phase = 1'b1;
                    end
                    else if (dma_on)
                    begin
                        r.oam_write = 1'b1;
                        r.oam_index = dma_idx;
                        r.oam_data = dma_buf;
                        dma_idx = dma_idx + 8'd1;
                        if (dma_idx == 8'h00)
                            dma_on = 1'b0;
                        dma_wr_phase = 1'b0;
                    end
                    else
                        r.cpu_step = 1'b1;
                end
                r.nmi_to_cpu = w.nmi_request;
                tick_cnt = (tick_cnt + 1 >= CPU_DIVIDE) ? 0 : tick_cnt + 1;
            end
            default:
                ;
        endcase
        r.dma_busy = dma_on;
        return r;
    endfunction

    task automatic field_cmp(input string fname, input int unsigned e,
                             input int unsigned g);
        if (e != g)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("response word %0d, %s: expected %0h, got %0h",
                         rsp_cnt, fname, e, g);
        end
    endtask

    // random request word; address picks lean on the decode boundaries
    function automatic req_word_t rand_req(input bit allow_trig);
        req_word_t   w;
        int unsigned k;
        w.write_data    = 8'($urandom);
        w.ext_read_data = 8'($urandom);
        w.ext_read_ok   = ($urandom_range(0, 3) != 0);
        w.pad_buttons_0 = 8'($urandom);
        w.pad_buttons_1 = 8'($urandom);
        w.nmi_request   = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 99);
        if (k < 45)
            w.mode = MODE_TICK;
        else if (k < 70)
            w.mode = MODE_READ;
        else if (k < 97)
            w.mode = MODE_WRITE;
        else
            w.mode = MODE_NONE;
        k = $urandom_range(0, 99);
        if (k < 40)
            w.addr = 16'($urandom_range(0, 16'h1FFF));
        else if (k < 55)
            w.addr = {15'h200B, 1'($urandom_range(0, 1))};  // either pad port
        else if (k < 65)
            w.addr = 16'($urandom_range(16'h2000, 16'h3FFF));
        else if (k < 72)
            w.addr = DMA_TRIG;
        else if (k < 80)
            w.addr = 16'h4000 + 16'($urandom_range(0, 31));
        else
            w.addr = 16'($urandom);
        // keep a running transfer alive when asked to
        if (!allow_trig && w.mode == MODE_WRITE && w.addr == DMA_TRIG)
            w.mode = MODE_READ;
        return w;
    endfunction

    // present one word and hold it until taken; entered and left at a
    // falling edge, with an occasional gap in front of the word
    task automatic send_word(input req_word_t w, input bit typed,
                             input rsp_word_t typed_rsp);
        if (!calm && (sent_cnt % 200) < 140 && $urandom_range(0, 9) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        drv_typed = typed;
        drv_typed_rsp = typed_rsp;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_cnt++;
        @(negedge clk);
    endtask

    // stop sending until the block has returned everything it owes
    task automatic drain;
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (rsp_q.size() != 0);
    endtask

    // response side: stall in bursts, quiet stretches in between
    initial
    begin
        int unsigned hold;
        int unsigned cyc;
        hold = 0;
        cyc = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold != 0)
                hold--;
            else if (!calm && (cyc % 300) < 200 && $urandom_range(0, 11) == 0)
                hold = $urandom_range(1, 14);
            rsp_stall <= (hold != 0);
        end
    end

    // scoreboard: words taken in are predicted at the edge that takes them,
    // words coming out are matched against the oldest prediction
    always @(posedge clk)
    begin
        rsp_word_t want;
        rsp_word_t pred;
        if (req_valid && !req_stall)
        begin
            pred = bus_predict(req);
            rsp_q.push_back(drv_typed ? drv_typed_rsp : pred);
        end
        if (rsp_valid && !rsp_stall)
        begin
            if (rsp_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("response word %0d arrived with none owed: %h", rsp_cnt, rsp);
            end
            else
            begin
                want = rsp_q.pop_front();
                field_cmp("read_data",       want.read_data,       rsp.read_data);
                field_cmp("accepted",        want.accepted,        rsp.accepted);
                field_cmp("target",          want.target,          rsp.target);
                field_cmp("dma_source_addr", want.dma_source_addr, rsp.dma_source_addr);
                field_cmp("cpu_step",        want.cpu_step,        rsp.cpu_step);
                field_cmp("oam_write",       want.oam_write,       rsp.oam_write);
                field_cmp("oam_index",       want.oam_index,       rsp.oam_index);
                field_cmp("oam_data",        want.oam_data,        rsp.oam_data);
                field_cmp("nmi_to_cpu",      want.nmi_to_cpu,      rsp.nmi_to_cpu);
                field_cmp("dma_busy",        want.dma_busy,        rsp.dma_busy);
            end
            rsp_cnt++;
        end
        // watchdog on cycles where no word moves on either side
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("[console_cpu_bus_with_sprite_dma_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        req_word_t w;
        rsp_word_t tr;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        drv_typed = 1'b0;
        drv_typed_rsp = '0;

        // bench state matches the block after reset
        foreach (ram_img[i])
            ram_img[i] = 8'h00;
        pad_sr[0] = 8'h00;
        pad_sr[1] = 8'h00;
        dma_pg = 8'h00;
        dma_idx = 8'h00;
        dma_buf = 8'h00;
        dma_on = 1'b0;
        dma_wr_phase = 1'b0;
        tick_cnt = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; the block holds req_stall through its ram clear
        for (int i = 0; i < N_DIR; i++)
        begin
            w.mode          = DIR_TAB[i].mode;
            w.addr          = DIR_TAB[i].addr;
            w.write_data    = DIR_TAB[i].wd;
            w.ext_read_data = DIR_TAB[i].ext;
            w.ext_read_ok   = DIR_TAB[i].ok;
            w.pad_buttons_0 = DIR_TAB[i].p0;
            w.pad_buttons_1 = DIR_TAB[i].p1;
            w.nmi_request   = DIR_TAB[i].nmi;
            tr = '0;
            tr.read_data  = DIR_TAB[i].rd;
            tr.accepted   = DIR_TAB[i].acc;
            tr.target     = DIR_TAB[i].tgt;
            tr.cpu_step   = DIR_TAB[i].cpu;
            tr.nmi_to_cpu = DIR_TAB[i].nmo;
            tr.dma_busy   = DIR_TAB[i].busy;
            send_word(w, DIR_TAB[i].chk, tr);
        end

        // hold off until the block is empty before the random part
        drain;

        // a long stretch of one transfer, from the io page or from ram,
        // ticks mostly, cpu traffic mixed in, no restarts
        w = rand_req(1'b1);
        w.mode = MODE_WRITE;
        w.addr = DMA_TRIG;
        w.write_data = ($urandom_range(0, 1) != 0) ? 8'h40 : 8'($urandom_range(0, 7));
        send_word(w, 1'b0, '0);
        for (int n = 0; n < XFER_WORDS; n++)
        begin
            w = rand_req(1'b0);
            if ($urandom_range(0, 9) != 0)
                w.mode = MODE_TICK;
            send_word(w, 1'b0, '0);
        end

        // mixed traffic with restarts from random pages; a second hold-off
        // halfway, and no gaps or stalls at the end
        for (int n = 0; n < MIX_WORDS; n++)
        begin
            if (n == MIX_WORDS / 2)
                drain;
            if (n == MIX_WORDS - CALM_WORDS)
                calm = 1'b1;
            send_word(rand_req(1'b1), 1'b0, '0);
        end

        drain;
        repeat (8) @(negedge clk);
        if (err_cnt == 0 && rsp_q.size() == 0)
            $display("[console_cpu_bus_with_sprite_dma_core] OK");
        else
            $display("[console_cpu_bus_with_sprite_dma_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
